FILE: rtl/core/fir_filtered_temperature_pid_assert.svh
// ----------------------------------------------------------------------------
// fir_filtered_temperature_pid_assert.svh
// Assertion macros shared by the temperature loop modules.
// ----------------------------------------------------------------------------
`ifndef FIR_FILTERED_TEMPERATURE_PID_ASSERT_SVH
`define FIR_FILTERED_TEMPERATURE_PID_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during rst
`define FFTP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during rst
`define FFTP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/fftp_pkg.sv
// ----------------------------------------------------------------------------
// fftp_pkg
// Types, widths, constants and tap table of the filtered temperature loop.
// ----------------------------------------------------------------------------
package fftp_pkg;

  // Delay line length
  localparam int TAP_COUNT = 10;
  localparam int CNT_W     = (TAP_COUNT > 2) ? $clog2(TAP_COUNT) : 1;

  // Field widths
  localparam int SAMPLE_W = 10;
  localparam int TAP_W    = 16;
  localparam int CFG_W    = 16;
  localparam int TEMP_W   = 16;
  localparam int ERR_W    = 17;
  localparam int DRIVE_W  = 16;
  localparam int DUTY_W   = 8;
  localparam int IDX_W    = 2;

  // Datapath widths
  localparam int PROD_W = SAMPLE_W + 1 + TAP_W;
  localparam int ACC_W  = PROD_W + 1;
  localparam int SCL_W  = ACC_W + 16;
  localparam int TSUM_W = SCL_W + 2;
  localparam int MUL_W  = CFG_W + ERR_W;
  localparam int PACC_W = MUL_W + 3;

  // Register indexes
  localparam logic [IDX_W-1:0] REG_SETPOINT   = 2'd0;
  localparam logic [IDX_W-1:0] REG_GAIN_NOW   = 2'd1;
  localparam logic [IDX_W-1:0] REG_GAIN_PREV1 = 2'd2;
  localparam logic [IDX_W-1:0] REG_GAIN_PREV2 = 2'd3;

  // Register reset values
  localparam logic signed [CFG_W-1:0] SETPOINT_RST   = 16'sd3200;
  localparam logic signed [CFG_W-1:0] GAIN_NOW_RST   = -16'sd15360;
  localparam logic signed [CFG_W-1:0] GAIN_PREV1_RST = 16'sd20813;
  localparam logic signed [CFG_W-1:0] GAIN_PREV2_RST = -16'sd5579;

  // Count to temperature mapping, Q.31 offset and Q.16 slope
  localparam logic signed [15:0]       SCALE_K  = 16'sd32383;
  localparam logic signed [TSUM_W-1:0] T_OFFSET = 46'sd746192585622;
  localparam logic signed [TSUM_W-1:0] T_ROUND  = 46'sd16777216;
  localparam logic signed [TSUM_W-1:0] TEMP_HI  = 46'sd32767;
  localparam logic signed [TSUM_W-1:0] TEMP_LO  = -46'sd32768;

  // Drive rounding and limits, Q8.8
  localparam logic signed [PACC_W-1:0] D_ROUND = 36'sd128;
  localparam logic signed [PACC_W-1:0] D_HI    = 36'sd65280;
  localparam logic signed [PACC_W-1:0] D_LO    = 36'sd0;
  localparam logic [DRIVE_W-1:0]       DRIVE_MAX = 16'd65280;

  // Low-pass taps, Q1.15
  localparam int NUM_TAPS_DEF = 10;
  localparam logic signed [TAP_W-1:0] TAPS [NUM_TAPS_DEF] = '{
    -16'sd180, 16'sd494, -16'sd605, -16'sd2279, 16'sd18954,
    16'sd18954, -16'sd2279, -16'sd605, 16'sd494, -16'sd180
  };

  // Tap of a given position; positions past the table are zero
  function automatic logic signed [TAP_W-1:0] tap_coef(input logic [4:0] idx);
    logic signed [TAP_W-1:0] c;
    c = '0;
    if (idx < 5'd10) begin
      c = TAPS[idx[3:0]];
    end
    return c;
  endfunction

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FILT,
    ST_SCALE,
    ST_TEMP,
    ST_MAC0,
    ST_MAC1,
    ST_MAC2,
    ST_MAC3,
    ST_DRIVE,
    ST_DONE
  } state_t;

  // Operand choice of the shared multiplier
  typedef enum logic [1:0] {
    SEL_NOW,
    SEL_PREV1,
    SEL_PREV2
  } mac_sel_t;

  // Controls from the sequencer to the PID unit
  typedef struct packed {
    logic     scale_en;
    logic     temp_en;
    logic     mul_en;
    mac_sel_t mul_sel;
    logic     add_en;
    logic     drive_en;
  } pid_ctrl_t;

endpackage

FILE: rtl/core/fftp_tap_cell.sv
// ----------------------------------------------------------------------------
// fftp_tap_cell
// One delay-line stage: holds a sample and adds its tap product to the
// partial sum passed along from the previous stage.
// ----------------------------------------------------------------------------
module fftp_tap_cell
  import fftp_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     shift_en,
  input  logic signed [TAP_W-1:0]  tap,
  input  logic [SAMPLE_W-1:0]      sample_in,
  input  logic signed [ACC_W-1:0]  psum_in,
  output logic [SAMPLE_W-1:0]      sample_out,
  output logic signed [ACC_W-1:0]  psum_out
);

  logic [SAMPLE_W-1:0]     sample;
  logic signed [ACC_W-1:0] psum;
  logic signed [PROD_W-1:0] prod;

  // Shift the sample in on an accepted item
  always_ff @(posedge clk) begin
    if (rst) begin
      sample <= '0;
    end else if (shift_en) begin
      sample <= sample_in;
    end
  end

  // Tap product against a fixed coefficient
  assign prod = $signed({1'b0, sample}) * tap;

  // Advance the partial sum one stage
  always_ff @(posedge clk) begin
    psum <= psum_in + ACC_W'(prod);
  end

  assign sample_out = sample;
  assign psum_out   = psum;

endmodule

FILE: rtl/core/fftp_pid_unit.sv
// ----------------------------------------------------------------------------
// fftp_pid_unit
// Maps the filtered count to temperature, forms the error and runs the
// incremental PID on one shared multiplier.
// ----------------------------------------------------------------------------
module fftp_pid_unit
  import fftp_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  pid_ctrl_t                ctrl,
  input  logic signed [ACC_W-1:0]  filt_sum,
  input  logic signed [CFG_W-1:0]  setpoint,
  input  logic signed [CFG_W-1:0]  gain_now,
  input  logic signed [CFG_W-1:0]  gain_prev1,
  input  logic signed [CFG_W-1:0]  gain_prev2,
  output logic [DRIVE_W-1:0]       drive,
  output logic signed [TEMP_W-1:0] temp
);

  logic signed [SCL_W-1:0]  scaled;
  logic signed [TSUM_W-1:0] tsum;
  logic signed [TSUM_W-1:0] tshift;
  logic signed [TEMP_W-1:0] temp_next;
  logic signed [ERR_W-1:0]  err;
  logic signed [ERR_W-1:0]  err_next;
  logic signed [ERR_W-1:0]  error_back1;
  logic signed [ERR_W-1:0]  error_back2;
  logic signed [CFG_W-1:0]  mul_a;
  logic signed [ERR_W-1:0]  mul_b;
  logic signed [MUL_W-1:0]  prod;
  logic signed [PACC_W-1:0] pacc;
  logic signed [PACC_W-1:0] dsum;
  logic signed [PACC_W-1:0] dshift;
  logic [DRIVE_W-1:0]       drive_next;
  logic [DRIVE_W-1:0]       drive_prev;

  // Scale the filtered count
  always_ff @(posedge clk) begin
    if (ctrl.scale_en) begin
      scaled <= filt_sum * SCALE_K;
    end
  end

  // Offset, round, shift down to Q10.6 and saturate
  always_comb begin
    tsum   = T_OFFSET - TSUM_W'(scaled) + T_ROUND;
    tshift = tsum >>> 25;
    if (tshift > TEMP_HI) begin
      temp_next = TEMP_HI[TEMP_W-1:0];
    end else if (tshift < TEMP_LO) begin
      temp_next = TEMP_LO[TEMP_W-1:0];
    end else begin
      temp_next = tshift[TEMP_W-1:0];
    end
    err_next = ERR_W'(setpoint) - ERR_W'(temp_next);
  end

  // Hold temperature and present error
  always_ff @(posedge clk) begin
    if (ctrl.temp_en) begin
      temp <= temp_next;
      err  <= err_next;
    end
  end

  // Pick gain and error for the shared multiplier
  always_comb begin
    case (ctrl.mul_sel)
      SEL_NOW: begin
        mul_a = gain_now;
        mul_b = err;
      end
      SEL_PREV1: begin
        mul_a = gain_prev1;
        mul_b = error_back1;
      end
      SEL_PREV2: begin
        mul_a = gain_prev2;
        mul_b = error_back2;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Register the product; preload the accumulator with the previous drive, then accumulate
  always_ff @(posedge clk) begin
    if (ctrl.mul_en) begin
      prod <= mul_a * mul_b;
    end
    if (ctrl.temp_en) begin
      pacc <= $signed({{(PACC_W - DRIVE_W - 8){1'b0}}, drive_prev, 8'b0});
    end else if (ctrl.add_en) begin
      pacc <= pacc + PACC_W'(prod);
    end
  end

  // Round to Q8.8 and clamp to 0..255.0
  always_comb begin
    dsum   = pacc + D_ROUND;
    dshift = dsum >>> 8;
    if (dshift > D_HI) begin
      drive_next = DRIVE_MAX;
    end else if (dshift < D_LO) begin
      drive_next = '0;
    end else begin
      drive_next = dshift[DRIVE_W-1:0];
    end
  end

  // Commit drive and age the error history
  always_ff @(posedge clk) begin
    if (rst) begin
      drive_prev  <= '0;
      error_back1 <= '0;
      error_back2 <= '0;
    end else if (ctrl.drive_en) begin
      drive_prev  <= drive_next;
      error_back1 <= err;
      error_back2 <= error_back1;
    end
  end

  assign drive = drive_prev;

`include "fir_filtered_temperature_pid_assert.svh"

  `FFTP_ASSERT_NOW(a_drive_in_range, 1'b1, drive_prev <= DRIVE_MAX, "drive above 255.0")
  `FFTP_ASSERT_NEXT(a_age1, ctrl.drive_en, error_back1 == $past(err), "error not kept")
  `FFTP_ASSERT_NEXT(a_age2, ctrl.drive_en, error_back2 == $past(error_back1), "history stuck")

endmodule

FILE: rtl/core/fir_filtered_temperature_pid.sv
// ----------------------------------------------------------------------------
// fir_filtered_temperature_pid
// Sensor sample -> 10-tap low-pass -> temperature -> incremental PID duty.
//
//   channel  | handshake                   | payload
//   ---------+-----------------------------+--------------------------
//   sample   | sample_valid / sample_stall | adc_sample
//   result   | result_valid / result_stall | duty, temperature
//   config   | cfg_write                   | cfg_index, cfg_data
//
// Each accepted item lets the partial sum ripple through the chain of tap
// cells one stage a cycle; then a separate multiplier scales the filtered
// count and one shared multiplier forms the three PID products, before the
// result is registered. rst is synchronous and restores the register
// defaults and clears the history. sample_stall is high while an item is
// in work; a stalled result holds and the next item waits until it leaves.
// ----------------------------------------------------------------------------
module fir_filtered_temperature_pid
  import fftp_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     sample_valid,
  output logic                     sample_stall,
  input  logic [SAMPLE_W-1:0]      adc_sample,
  output logic                     result_valid,
  input  logic                     result_stall,
  output logic [DUTY_W-1:0]        duty,
  output logic signed [TEMP_W-1:0] temperature,
  input  logic                     cfg_write,
  input  logic [IDX_W-1:0]         cfg_index,
  input  logic [CFG_W-1:0]         cfg_data
);

  state_t     state;
  state_t     state_next;
  logic [CNT_W-1:0] cnt;
  logic [CNT_W-1:0] cnt_next;
  pid_ctrl_t  ctrl;
  logic       accept;
  logic       out_load;
  logic       out_free;

  logic signed [CFG_W-1:0] setpoint;
  logic signed [CFG_W-1:0] gain_now;
  logic signed [CFG_W-1:0] gain_prev1;
  logic signed [CFG_W-1:0] gain_prev2;

  logic [SAMPLE_W-1:0]     smp  [TAP_COUNT];
  logic signed [ACC_W-1:0] psum [TAP_COUNT];
  logic [DRIVE_W-1:0]      drive;
  logic signed [TEMP_W-1:0] temp;

  assign sample_stall = (state != ST_IDLE);
  assign accept       = sample_valid && !sample_stall;
  assign out_free     = !result_valid || !result_stall;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      setpoint   <= SETPOINT_RST;
      gain_now   <= GAIN_NOW_RST;
      gain_prev1 <= GAIN_PREV1_RST;
      gain_prev2 <= GAIN_PREV2_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_SETPOINT:   setpoint   <= cfg_data;
        REG_GAIN_NOW:   gain_now   <= cfg_data;
        REG_GAIN_PREV1: gain_prev1 <= cfg_data;
        REG_GAIN_PREV2: gain_prev2 <= cfg_data;
        default: ;
      endcase
    end
  end

  // Chain of tap cells
  for (genvar i = 0; i < TAP_COUNT; i++) begin : g_cell
    logic [SAMPLE_W-1:0]     s_in;
    logic signed [ACC_W-1:0] p_in;
    if (i == 0) begin : g_head
      assign s_in = adc_sample;
      assign p_in = '0;
    end else begin : g_link
      assign s_in = smp[i-1];
      assign p_in = psum[i-1];
    end
    fftp_tap_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .shift_en   (accept),
      .tap        (tap_coef(5'(i))),
      .sample_in  (s_in),
      .psum_in    (p_in),
      .sample_out (smp[i]),
      .psum_out   (psum[i])
    );
  end

  // Temperature and PID datapath
  fftp_pid_unit u_pid (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (ctrl),
    .filt_sum   (psum[TAP_COUNT-1]),
    .setpoint   (setpoint),
    .gain_now   (gain_now),
    .gain_prev1 (gain_prev1),
    .gain_prev2 (gain_prev2),
    .drive      (drive),
    .temp       (temp)
  );

  // State register and ripple counter
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  // Next state and datapath controls
  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    ctrl       = '{scale_en: 1'b0, temp_en: 1'b0, mul_en: 1'b0,
                   mul_sel: SEL_NOW, add_en: 1'b0, drive_en: 1'b0};
    out_load   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        cnt_next = '0;
        if (accept) begin
          state_next = ST_FILT;
        end
      end
      ST_FILT: begin
        cnt_next = cnt + 1'b1;
        if (cnt == CNT_W'(TAP_COUNT - 1)) begin
          state_next = ST_SCALE;
        end
      end
      ST_SCALE: begin
        ctrl.scale_en = 1'b1;
        state_next    = ST_TEMP;
      end
      ST_TEMP: begin
        ctrl.temp_en = 1'b1;
        state_next   = ST_MAC0;
      end
      ST_MAC0: begin
        ctrl.mul_en  = 1'b1;
        ctrl.mul_sel = SEL_NOW;
        state_next   = ST_MAC1;
      end
      ST_MAC1: begin
        ctrl.mul_en  = 1'b1;
        ctrl.mul_sel = SEL_PREV1;
        ctrl.add_en  = 1'b1;
        state_next   = ST_MAC2;
      end
      ST_MAC2: begin
        ctrl.mul_en  = 1'b1;
        ctrl.mul_sel = SEL_PREV2;
        ctrl.add_en  = 1'b1;
        state_next   = ST_MAC3;
      end
      ST_MAC3: begin
        ctrl.add_en = 1'b1;
        state_next  = ST_DRIVE;
      end
      ST_DRIVE: begin
        ctrl.drive_en = 1'b1;
        state_next    = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Output register: load a finished item, drop it once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      duty        <= drive[DRIVE_W-1:DRIVE_W-DUTY_W];
      temperature <= temp;
    end
  end

`include "fir_filtered_temperature_pid_assert.svh"

  `FFTP_ASSERT_NEXT(a_accept_starts, accept, state == ST_FILT && cnt == '0, "accept did not start the filter pass")
  `FFTP_ASSERT_NEXT(a_done_loads, state == ST_DONE && out_free, result_valid && state == ST_IDLE, "finished item not loaded")
  `FFTP_ASSERT_NOW(a_one_in_work, state != ST_IDLE, sample_stall, "input open while an item is in work")

endmodule
